/* design/bps_pkg.sv */
// Shared types and constants for the buzzer pattern sequencer.
// No dependencies; every other design file refers to this package by scoped name.
package bps_pkg;

	localparam int unsigned CountW = 16;
	localparam int unsigned PhaseW = 3;
	localparam int unsigned PatW   = 2;
	localparam int unsigned ApbAw  = 3;
	localparam int unsigned ApbDw  = 32;

	// pattern codes
	localparam logic [PatW-1:0] PAT_OFF    = 2'd0;
	localparam logic [PatW-1:0] PAT_ONCE   = 2'd1;
	localparam logic [PatW-1:0] PAT_DOUBLE = 2'd2;
	localparam logic [PatW-1:0] PAT_BOOT   = 2'd3;

	// action codes
	localparam logic ACT_TICK    = 1'b0;
	localparam logic ACT_TRIGGER = 1'b1;

	// phase codes inside double and boot patterns
	localparam logic [PhaseW-1:0] PH_BEEP1 = 3'd0;
	localparam logic [PhaseW-1:0] PH_GAP1  = 3'd1;
	localparam logic [PhaseW-1:0] PH_BEEP2 = 3'd2;
	localparam logic [PhaseW-1:0] PH_GAP2  = 3'd3;
	localparam logic [PhaseW-1:0] PH_BEEP3 = 3'd4;

	// timing in ticks
	localparam logic [CountW-1:0] FIRST_TICK = 16'd1;
	localparam logic [CountW-1:0] BEEP_TICKS = 16'd5;
	localparam logic [CountW-1:0] GAP_TICKS  = 16'd10;

	// register word indexes and reset values
	localparam logic [ApbAw-3:0]  REG_ONCE_TICKS = 1'd0;
	localparam logic [CountW-1:0] ONCE_TICKS_RST = 16'd10;

	typedef struct packed {
		logic buzzer_on;
		logic busy_res;
	} result_t;

endpackage

/* design/bps_if.sv */
// Valid/ready channel interfaces: trigger/tick words in, buzzer status words out.
// Depends on bps_pkg for field widths.
interface bps_in_if;
	logic                       valid;
	logic                       ready;
	logic                       action;
	logic [bps_pkg::PatW-1:0]   pattern;

	modport source (output valid, action, pattern, input ready);
	modport sink   (input valid, action, pattern, output ready);
endinterface

interface bps_out_if;
	logic valid;
	logic ready;
	logic buzzer_on;
	logic busy_res;

	modport source (output valid, buzzer_on, busy_res, input ready);
	modport sink   (input valid, buzzer_on, busy_res, output ready);
endinterface

/* design/bps_apb_regs.sv */
// APB register bank: holds once_ticks.
// Depends on bps_pkg.
module bps_apb_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bps_pkg::ApbAw-1:0]    paddr,
	input  logic [bps_pkg::ApbDw-1:0]    pwdata,
	output logic [bps_pkg::ApbDw-1:0]    prdata,
	output logic                         pready,
	output logic [bps_pkg::CountW-1:0]   once_ticks
);

	logic [bps_pkg::CountW-1:0] once_ticks_q;
	logic [bps_pkg::ApbAw-3:0]  word_idx;
	logic                       wr_en;

	assign word_idx = paddr[bps_pkg::ApbAw-1:2];
	assign pready   = 1'b1;
	assign wr_en    = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			once_ticks_q <= bps_pkg::ONCE_TICKS_RST;
		end else if (wr_en && word_idx == bps_pkg::REG_ONCE_TICKS) begin
			once_ticks_q <= pwdata[bps_pkg::CountW-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (word_idx == bps_pkg::REG_ONCE_TICKS) begin
			prdata = {{(bps_pkg::ApbDw - bps_pkg::CountW){1'b0}}, once_ticks_q};
		end
	end

	assign once_ticks = once_ticks_q;

endmodule

/* design/bps_seq_core.sv */
// Pattern state machine: per accepted word computes next state and the result word.
// Depends on bps_pkg.
module bps_seq_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic                         action,
	input  logic [bps_pkg::PatW-1:0]     pattern,
	input  logic [bps_pkg::CountW-1:0]   once_ticks,
	output bps_pkg::result_t             result
);

	logic [bps_pkg::PatW-1:0]   pattern_q, pattern_d;
	logic [bps_pkg::CountW-1:0] count_q, count_d, count_inc;
	logic [bps_pkg::PhaseW-1:0] phase_q, phase_d, phase_inc;
	logic                       tone_q, tone_d;
	logic                       in_beep, in_gap, last_beep;

	assign count_inc = count_q + 1'b1;
	assign phase_inc = phase_q + 1'b1;

	always_comb begin
		in_beep   = 1'b0;
		in_gap    = 1'b0;
		last_beep = 1'b0;
		if (pattern_q == bps_pkg::PAT_DOUBLE) begin
			in_beep   = (phase_q == bps_pkg::PH_BEEP1) || (phase_q == bps_pkg::PH_BEEP2);
			in_gap    = (phase_q == bps_pkg::PH_GAP1);
			last_beep = (phase_q == bps_pkg::PH_BEEP2);
		end else if (pattern_q == bps_pkg::PAT_BOOT) begin
			in_beep   = (phase_q == bps_pkg::PH_BEEP1) || (phase_q == bps_pkg::PH_BEEP2)
			         || (phase_q == bps_pkg::PH_BEEP3);
			in_gap    = (phase_q == bps_pkg::PH_GAP1) || (phase_q == bps_pkg::PH_GAP2);
			last_beep = (phase_q == bps_pkg::PH_BEEP3);
		end
	end

	always_comb begin
		pattern_d = pattern_q;
		count_d   = count_q;
		phase_d   = phase_q;
		tone_d    = tone_q;
		if (action == bps_pkg::ACT_TRIGGER) begin
			pattern_d = pattern;
			count_d   = '0;
			phase_d   = '0;
			tone_d    = 1'b0;
		end else if (pattern_q != bps_pkg::PAT_OFF) begin
			count_d = count_inc;
			if (pattern_q == bps_pkg::PAT_ONCE) begin
				if (count_inc == bps_pkg::FIRST_TICK) begin
					tone_d = 1'b1;
				end else if (count_inc >= once_ticks) begin
					tone_d    = 1'b0;
					pattern_d = bps_pkg::PAT_OFF;
				end
			end else if (in_beep) begin
				if (count_inc == bps_pkg::FIRST_TICK) begin
					tone_d = 1'b1;
				end else if (count_inc >= bps_pkg::BEEP_TICKS) begin
					tone_d = 1'b0;
					if (last_beep) begin
						pattern_d = bps_pkg::PAT_OFF;
					end else begin
						phase_d = phase_inc;
						count_d = '0;
					end
				end
			end else if (in_gap) begin
				if (count_inc >= bps_pkg::GAP_TICKS) begin
					phase_d = phase_inc;
					count_d = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= bps_pkg::PAT_OFF;
			count_q   <= '0;
			phase_q   <= '0;
			tone_q    <= 1'b0;
		end else if (accept) begin
			pattern_q <= pattern_d;
			count_q   <= count_d;
			phase_q   <= phase_d;
			tone_q    <= tone_d;
		end
	end

	// result reflects the state after this word
	assign result.buzzer_on = tone_d;
	assign result.busy_res  = (pattern_d != bps_pkg::PAT_OFF);

	a_trigger_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && action == bps_pkg::ACT_TRIGGER |=> count_q == '0 && phase_q == '0 && !tone_q)
		else $error("trigger did not clear sequencer state");

	a_tone_needs_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		tone_q |-> pattern_q != bps_pkg::PAT_OFF)
		else $error("tone on while idle");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= bps_pkg::PH_BEEP3)
		else $error("phase beyond last beep");

endmodule

/* design/bps_out_skid.sv */
// Two-entry output buffer (result register plus skid) for the status channel.
// Depends on bps_pkg.
module bps_out_skid (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  bps_pkg::result_t   push_data,
	output logic               push_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output bps_pkg::result_t   out_data
);

	logic             main_valid_q, skid_valid_q;
	bps_pkg::result_t main_q, skid_q;
	logic             pop;

	assign push_ready = !skid_valid_q;
	assign pop        = main_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					main_valid_q <= push;
				end
			end else if (push) begin
				if (main_valid_q) begin
					skid_valid_q <= 1'b1;
				end else begin
					main_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && skid_valid_q) begin
			main_q <= skid_q;
		end else if (push && (pop || !main_valid_q)) begin
			main_q <= push_data;
		end
		if (push && main_valid_q && !pop) begin
			skid_q <= push_data;
		end
	end

	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> main_valid_q)
		else $error("skid entry held with empty result register");

endmodule

/* design/buzzer_pattern_sequencer.sv */
// Top level of the buzzer pattern sequencer: APB registers, pattern core, output buffer.
// Depends on bps_pkg, bps_if, bps_apb_regs, bps_seq_core, bps_out_skid.
//
//  channel  | dir | word fields          | accepted when
//  ---------+-----+----------------------+----------------------------
//  in_ch    | in  | action, pattern      | in_ch.valid & in_ch.ready
//  out_ch   | out | buzzer_on, busy_res  | out_ch.valid & out_ch.ready
//  apb      | in  | once_ticks @ 0x0     | psel & penable & pwrite
//
// One word per cycle while in_ch.ready is high: each accepted word updates the
// sequencer state in the same edge and its status word is registered into the
// output buffer (result register, or skid stage if the result register is held).
// in_ch.ready drops only when both output entries are full (result register
// and skid stage), i.e. after two words wait on a stalled out_ch.
// Reset (arst_n low, asynchronous): idle, silent, counter and phase zero,
// once_ticks = 10, output buffer empty.
module buzzer_pattern_sequencer (
	input  logic                         clk,
	input  logic                         arst_n,
	bps_in_if.sink                       in_ch,
	bps_out_if.source                    out_ch,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bps_pkg::ApbAw-1:0]    paddr,
	input  logic [bps_pkg::ApbDw-1:0]    pwdata,
	output logic [bps_pkg::ApbDw-1:0]    prdata,
	output logic                         pready
);

	logic [bps_pkg::CountW-1:0] once_ticks;
	logic                       in_accept;
	logic                       buf_ready;
	bps_pkg::result_t           core_result;
	bps_pkg::result_t           out_word;

	bps_apb_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.once_ticks (once_ticks)
	);

	// word enters the core only when the buffer has room for its status
	assign in_ch.ready = buf_ready;
	assign in_accept   = in_ch.valid && buf_ready;

	bps_seq_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (in_accept),
		.action     (in_ch.action),
		.pattern    (in_ch.pattern),
		.once_ticks (once_ticks),
		.result     (core_result)
	);

	bps_out_skid u_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (in_accept),
		.push_data  (core_result),
		.push_ready (buf_ready),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.out_data   (out_word)
	);

	assign out_ch.buzzer_on = out_word.buzzer_on;
	assign out_ch.busy_res  = out_word.busy_res;

endmodule
